// ----- src/bpad_pkg.sv -----
`timescale 1ns / 1ps

package bpad_pkg;

  // Image geometry and the largest supported dimension.
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // Palette geometry.
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = $clog2(PAL_DEPTH);
  localparam int unsigned WORD_W    = 32;

  // Queue depths between the front, the back and the result port.
  localparam int unsigned JOBQ_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH = 4;

  // Input opcodes.
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_DATA      = 1'b1;

  // Pixel format codes; the two unused codes decode as 8 bit.
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_2BPP  = 3'd1;
  localparam logic [2:0] FMT_4BPP  = 3'd2;
  localparam logic [2:0] FMT_8BPP  = 3'd3;
  localparam logic [2:0] FMT_24BPP = 3'd4;
  localparam logic [2:0] FMT_32BPP = 3'd5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_FORMAT  = 2'd2,
    CFG_PADDING = 2'd3
  } cfg_reg_e;

  // Index size of a palette-based byte.
  typedef enum logic [1:0] {
    SUB_1BPP = 2'd0,
    SUB_2BPP = 2'd1,
    SUB_4BPP = 2'd2,
    SUB_8BPP = 2'd3
  } sub_fmt_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_PAL_WRITE = 2'd0,
    JOB_INDEXED   = 2'd1,
    JOB_DIRECT    = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [31:0] entry_word;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } out_item_t;

  // One job: a palette write, an indexed byte with its pixel count, or one
  // assembled pixel. The word holds alpha, red, green, blue from top to bottom.
  typedef struct packed {
    job_kind_e         kind;
    sub_fmt_e          sub_fmt;
    logic [7:0]        data;
    logic [WORD_W-1:0] word;
    logic [3:0]        count;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
  } job_t;

endpackage

// ----- src/bmp_pixel_array_decoder_top.sv -----
`timescale 1ns / 1ps
// A data byte's pixels pass through the job queue, the job register, the lookup stage and the
// result queue. The back end gives one result per cycle while the result queue has room and
// expands a byte one pixel at a time (up to 8 at 1 bit per pixel); a palette write gives no result,
// and the four-entry job queue accepts a new item every cycle while it has room.
// Reset clears positions, queues and registers (width 1, height 1, 8 bit, no padding);
// the palette is not cleared and holds no valid data until written.

module bmp_pixel_array_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  bpad_pkg::in_item_t         in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output bpad_pkg::out_item_t        out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  bpad_pkg::cfg_reg_e         cfg_index_i,
  input  logic [bpad_pkg::DIM_W-1:0] cfg_data_i
);
  import bpad_pkg::*;

  logic job_valid, job_pop;
  job_t job;

  // Front: configuration, classification and position tracking.
  bpad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  // Back: palette, pixel expansion and result queue.
  bpad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- src/bpad_front.sv -----
`timescale 1ns / 1ps

module bpad_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  bpad_pkg::in_item_t       in_item_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  bpad_pkg::cfg_reg_e       cfg_index_i,
  input  logic [bpad_pkg::DIM_W-1:0] cfg_data_i,
  output logic                     job_valid_o,
  input  logic                     job_pop_i,
  output bpad_pkg::job_t           job_o
);
  import bpad_pkg::*;

  localparam int unsigned JQ_AW = $clog2(JOBQ_DEPTH);
  localparam int unsigned JQ_CW = $clog2(JOBQ_DEPTH + 1);

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;
  logic [2:0]       fmt_q;
  logic [1:0]       pad_cfg_q;

  // Decoder position and partial pixel state.
  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [23:0]      pix_asm_q, pix_asm_d;
  logic [1:0]       bip_q, bip_d;
  logic [1:0]       padl_q, padl_d;

  // Job queue.
  job_t             jq_q [JOBQ_DEPTH];
  logic [JQ_AW-1:0] jq_wp_q, jq_rp_q;
  logic [JQ_CW-1:0] jq_cnt_q;

  logic             accept, is_data, is_sub, is_32, row_check, job_push, jq_pop;
  logic [DIM_W-1:0] w_eff, h_eff, col_ext, avail, col_sum, row_next;
  logic [3:0]       per, n_pix;
  logic [1:0]       need;
  sub_fmt_e         sub_fmt;
  logic [POS_W-1:0] row_out;
  job_t             job_in;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(1);
      height_q  <= DIM_W'(1);
      fmt_q     <= FMT_8BPP;
      pad_cfg_q <= 2'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:   width_q   <= cfg_data_i;
        CFG_HEIGHT:  height_q  <= cfg_data_i;
        CFG_FORMAT:  fmt_q     <= cfg_data_i[2:0];
        CFG_PADDING: pad_cfg_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to 1..4096.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > MAX_DIM) begin
      w_eff = MAX_DIM;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > MAX_DIM) begin
      h_eff = MAX_DIM;
    end else begin
      h_eff = height_q;
    end
  end

  // Format decode: index size, pixels per byte and whether the format is palette-based.
  always_comb begin
    is_sub  = 1'b1;
    sub_fmt = SUB_8BPP;
    per     = 4'd1;
    unique case (fmt_q) inside
      FMT_1BPP: begin
        sub_fmt = SUB_1BPP;
        per     = 4'd8;
      end
      FMT_2BPP: begin
        sub_fmt = SUB_2BPP;
        per     = 4'd4;
      end
      FMT_4BPP: begin
        sub_fmt = SUB_4BPP;
        per     = 4'd2;
      end
      FMT_24BPP, FMT_32BPP: is_sub = 1'b0;
      default: ;
    endcase
  end

  assign is_32    = (fmt_q == FMT_32BPP);
  assign need     = is_32 ? 2'd3 : 2'd2;
  assign accept   = push && !full;
  assign is_data  = (in_item_i.opcode == OP_DATA);
  assign col_ext  = {1'b0, col_q};
  assign avail    = (col_ext < w_eff) ? (w_eff - col_ext) : '0;
  assign n_pix    = (avail < {9'd0, per}) ? avail[3:0] : per;
  assign row_out  = POS_W'(h_eff - DIM_W'(1) - {1'b0, row_q});
  assign row_next = {1'b0, row_q} + DIM_W'(1);

  // Classify the item, advance the position and build the job.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pix_asm_d = pix_asm_q;
    bip_d     = bip_q;
    padl_d    = padl_q;
    col_sum   = col_ext;
    row_check = 1'b0;
    job_push  = 1'b0;
    job_in    = '0;
    job_in.column = col_q;
    job_in.row    = row_out;
    job_in.data   = in_item_i.data_byte;

    if (accept) begin
      if (!is_data) begin
        job_push     = 1'b1;
        job_in.kind  = JOB_PAL_WRITE;
        job_in.data  = in_item_i.entry_index;
        job_in.word  = in_item_i.entry_word;
      end else if (padl_q != '0) begin
        padl_d = padl_q - 2'd1;
      end else if (is_sub) begin
        pix_asm_d = '0;
        bip_d     = '0;
        row_check = 1'b1;
        col_sum   = col_ext + {9'd0, n_pix};
        if (n_pix != '0) begin
          job_push       = 1'b1;
          job_in.kind    = JOB_INDEXED;
          job_in.sub_fmt = sub_fmt;
          job_in.count   = n_pix;
        end
      end else if (bip_q >= need) begin
        pix_asm_d = '0;
        bip_d     = '0;
        row_check = 1'b1;
        if (col_ext < w_eff) begin
          col_sum      = col_ext + DIM_W'(1);
          job_push     = 1'b1;
          job_in.kind  = JOB_DIRECT;
          job_in.count = 4'd1;
          job_in.word  = is_32 ?
            {in_item_i.data_byte, pix_asm_q[23:16], pix_asm_q[15:0]} :
            {8'd0, in_item_i.data_byte, pix_asm_q[15:0]};
        end
      end else begin
        case (bip_q)
          2'd0: pix_asm_d[7:0]   = in_item_i.data_byte;
          2'd1: pix_asm_d[15:8]  = in_item_i.data_byte;
          2'd2: pix_asm_d[23:16] = in_item_i.data_byte;
          default: ;
        endcase
        bip_d = bip_q + 2'd1;
      end

      // End of row: wrap the column, step the row and arm the padding skip.
      if (row_check) begin
        if (col_sum >= w_eff) begin
          col_d  = '0;
          row_d  = (row_next >= h_eff) ? '0 : row_next[POS_W-1:0];
          padl_d = pad_cfg_q;
        end else begin
          col_d = col_sum[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pix_asm_q <= '0;
      bip_q     <= '0;
      padl_q    <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      pix_asm_q <= pix_asm_d;
      bip_q     <= bip_d;
      padl_q    <= padl_d;
    end
  end

  // Job queue toward the back.
  assign full        = (jq_cnt_q == JQ_CW'(JOBQ_DEPTH));
  assign job_valid_o = (jq_cnt_q != '0);
  assign job_o       = jq_q[jq_rp_q];
  assign jq_pop      = job_pop_i && job_valid_o;

  always_ff @(posedge clk_i) begin
    if (job_push) begin
      jq_q[jq_wp_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jq_wp_q  <= '0;
      jq_rp_q  <= '0;
      jq_cnt_q <= '0;
    end else begin
      if (job_push) begin
        jq_wp_q <= jq_wp_q + JQ_AW'(1);
      end
      if (jq_pop) begin
        jq_rp_q <= jq_rp_q + JQ_AW'(1);
      end
      case ({job_push, jq_pop})
        2'b10:   jq_cnt_q <= jq_cnt_q + JQ_CW'(1);
        2'b01:   jq_cnt_q <= jq_cnt_q - JQ_CW'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A padding byte never produces work.
  a_pad_no_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_data && padl_q != '0) |-> !job_push)
    else $error("padding byte produced a job");

  // An indexed job carries between one and eight pixels.
  a_idx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push && job_in.kind == JOB_INDEXED) |-> (job_in.count != '0 && job_in.count <= 4'd8))
    else $error("indexed job with bad pixel count");

  // A palette-based byte leaves no partial pixel behind.
  a_sub_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_data && padl_q == '0 && is_sub) |=> (bip_q == '0 && pix_asm_q == '0))
    else $error("partial pixel survived a palette-based byte");
`endif

endmodule

// ----- src/bpad_back.sv -----
`timescale 1ns / 1ps

module bpad_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  input  bpad_pkg::job_t      job_i,
  output logic                empty,
  input  logic                pop,
  output bpad_pkg::out_item_t out_item_o
);
  import bpad_pkg::*;

  localparam int unsigned OQ_AW = $clog2(OUTQ_DEPTH);
  localparam int unsigned OQ_CW = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic              direct;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
    logic              last;
  } px_meta_t;

  // Palette memory, undefined until written.
  logic [WORD_W-1:0] pal_mem [PAL_DEPTH];
  logic [WORD_W-1:0] pal_rd_q;

  // Job in progress.
  job_t cur_q, cur_d;
  logic cur_valid_q, cur_valid_d;

  // Lookup stage.
  logic     px_valid_q;
  px_meta_t px_q;

  // Result queue.
  out_item_t        oq_q [OUTQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_q, oq_rp_q;
  logic [OQ_CW-1:0] oq_cnt_q;

  logic              room, is_pal, issue, cur_done, take, oq_pop;
  logic [PAL_AW-1:0] idx;
  logic [7:0]        data_shift;
  logic [WORD_W-1:0] word_sel;
  out_item_t         res;

  // Pick the leading index of the byte and the byte shifted past it.
  always_comb begin
    unique case (cur_q.sub_fmt)
      SUB_1BPP: begin
        idx        = {7'd0, cur_q.data[7]};
        data_shift = {cur_q.data[6:0], 1'b0};
      end
      SUB_2BPP: begin
        idx        = {6'd0, cur_q.data[7:6]};
        data_shift = {cur_q.data[5:0], 2'd0};
      end
      SUB_4BPP: begin
        idx        = {4'd0, cur_q.data[7:4]};
        data_shift = {cur_q.data[3:0], 4'd0};
      end
      default: begin
        idx        = cur_q.data;
        data_shift = cur_q.data;
      end
    endcase
  end

  // A pixel may start only if the result queue has room for it and the one in flight.
  assign room     = ((oq_cnt_q + OQ_CW'(px_valid_q)) < OQ_CW'(OUTQ_DEPTH));
  assign is_pal   = cur_valid_q && (cur_q.kind == JOB_PAL_WRITE);
  assign issue    = cur_valid_q && (cur_q.kind != JOB_PAL_WRITE) && room;
  assign cur_done = is_pal ||
                    (issue && (cur_q.kind == JOB_DIRECT || cur_q.count == 4'd1));
  assign take      = job_valid_i && (!cur_valid_q || cur_done);
  assign job_pop_o = take;

  // Step through the job one pixel per cycle while the result queue has room, and load the next one behind it.
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    if (issue) begin
      cur_d.data   = data_shift;
      cur_d.count  = cur_q.count - 4'd1;
      cur_d.column = cur_q.column + POS_W'(1);
    end
    if (take) begin
      cur_d       = job_i;
      cur_valid_d = 1'b1;
    end else if (cur_done) begin
      cur_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      px_valid_q  <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      px_valid_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (issue) begin
      px_q.direct <= (cur_q.kind == JOB_DIRECT);
      px_q.word   <= cur_q.word;
      px_q.row    <= cur_q.row;
      px_q.column <= cur_q.column;
      px_q.last   <= (cur_q.kind == JOB_DIRECT) || (cur_q.count == 4'd1);
    end
  end

  // Palette write and registered lookup.
  always_ff @(posedge clk_i) begin
    if (is_pal) begin
      pal_mem[cur_q.data] <= cur_q.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pal_rd_q <= pal_mem[idx];
    end
  end

  // Split the word into color components.
  assign word_sel = px_q.direct ? px_q.word : pal_rd_q;

  always_comb begin
    res        = '0;
    res.row    = px_q.row;
    res.column = px_q.column;
    res.alpha  = word_sel[31:24];
    res.red    = word_sel[23:16];
    res.green  = word_sel[15:8];
    res.blue   = word_sel[7:0];
    res.last   = px_q.last;
  end

  // Result queue toward the output port.
  assign empty      = (oq_cnt_q == '0);
  assign out_item_o = oq_q[oq_rp_q];
  assign oq_pop     = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (px_valid_q) begin
      oq_q[oq_wp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (px_valid_q) begin
        oq_wp_q <= oq_wp_q + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + OQ_AW'(1);
      end
      case ({px_valid_q, oq_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
        2'b01:   oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Queued results plus the one in flight never exceed the queue.
  a_oq_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oq_cnt_q + OQ_CW'(px_valid_q)) <= OQ_CW'(OUTQ_DEPTH))
    else $error("result queue overcommitted");

  // A pixel leaving the lookup stage always finds a free slot.
  a_oq_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_valid_q |-> (oq_cnt_q < OQ_CW'(OUTQ_DEPTH)))
    else $error("result written into a full queue");

  // An indexed job in progress always has pixels left.
  a_cur_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.kind == JOB_INDEXED) |-> (cur_q.count != '0))
    else $error("indexed job with no pixels left");
`endif

endmodule
